@@ src/ppmd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the PPM pulse-train decoder: configuration register indexes,
// pulse-width limits and reset values. No dependencies.
package ppmd_pkg;

  typedef enum logic [0:0] {
    CFG_CHANNEL_ORDER  = 1'b0,
    CFG_SYNC_THRESHOLD = 1'b1
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned VALUE_W    = 15;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned COUNT_W    = 8;

  localparam logic [CFG_DATA_W-1:0] SYNC_THRESHOLD_RESET = 15'd6000;
  localparam logic [WIDTH_W-1:0]    WIDTH_MIN            = 11'd1000;
  localparam logic [WIDTH_W-1:0]    WIDTH_MAX            = 11'd2000;
  localparam logic [WIDTH_W:0]      WIDTH_MID            = 12'd1500;

endpackage

@@ src/ppm_pulse_train_decoder.sv @@
`timescale 1ns / 1ps
// PPM pulse-train decoder top level: edge timestamps in, sync and channel
// results out. Depends on ppmd_pkg.
//
//   channel   dir  bits  contents
//   s_*       in   16    edge_time
//   m_*       out  1+32  tuser: is_sync; tdata: channel_index, channel_value,
//                        frame_count
//   cfg_*     in   1+15  register index, write data
//
// One item is decoded per cycle unless stalled; the result is registered on accept.
// The single output register sets the rate: s_tready is high whenever that
// register is empty or being drained, so items flow back to back.
// Synchronous reset clears decoder state, configuration registers and m_tvalid.
// A stall on m_tready holds the result and stops accepting new items.
module ppm_pulse_train_decoder #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [15:0]                            s_tdata,   // [15:0] edge_time
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [31:0]                            m_tdata,   // [2:0] channel_index,
                                                            // [17:3] channel_value,
                                                            // [25:18] frame_count
  output logic                                   m_tuser,   // [0] is_sync
  input  logic                                   cfg_we,
  input  logic [0:0]                             cfg_addr,
  input  logic [ppmd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import ppmd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT + 1);

  logic                  channel_order;
  logic [CFG_DATA_W-1:0] sync_threshold;

  logic [EDGE_W-1:0]  last_edge_time;
  logic [SLOT_W-1:0]  slot_counter;
  logic               awaiting_sync;
  logic [COUNT_W-1:0] sync_total;

  logic [SLOT_W-1:0]  slot_counter_next;
  logic               awaiting_sync_next;
  logic [COUNT_W-1:0] sync_total_next;

  logic                      accept;
  logic [EDGE_W-1:0]         diff;
  logic                      past_end;
  logic                      is_gap;
  logic [EDGE_W-3:0]         half;
  logic [WIDTH_W-1:0]        w;
  logic signed [WIDTH_W:0]   off;
  logic signed [VALUE_W-1:0] off_x;
  logic signed [VALUE_W-1:0] value;
  logic [4:0]                ch_wide;
  logic [INDEX_W-1:0]        ch;
  logic                      res_valid;
  logic                      res_sync;

  logic                      is_sync_q;
  logic [INDEX_W-1:0]        channel_index_q;
  logic [VALUE_W-1:0]        channel_value_q;
  logic [COUNT_W-1:0]        frame_count_q;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_order  <= 1'b0;
      sync_threshold <= SYNC_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CHANNEL_ORDER:  channel_order  <= cfg_data[0];
        CFG_SYNC_THRESHOLD: sync_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff     = s_tdata - last_edge_time;
    past_end = (slot_counter >= SLOT_W'(SLOT_COUNT));
    is_gap   = !diff[EDGE_W-1] && (diff[EDGE_W-2:0] > sync_threshold);
    half     = diff[EDGE_W-2:1];

    if (diff[EDGE_W-1]) begin
      w = WIDTH_MIN;
    end else if (half > (EDGE_W-2)'(WIDTH_MAX)) begin
      w = WIDTH_MAX;
    end else if (half < (EDGE_W-2)'(WIDTH_MIN)) begin
      w = WIDTH_MIN;
    end else begin
      w = half[WIDTH_W-1:0];
    end
    // Gain of 20 as 16x + 4x.
    off   = $signed({1'b0, w}) - $signed(WIDTH_MID);
    off_x = VALUE_W'(off);
    value = (off_x <<< 4) + (off_x <<< 2);

    ch_wide = 5'(slot_counter);
    if (channel_order && ch_wide == 5'd0) begin
      ch_wide = 5'd2;
    end else if (channel_order && ch_wide == 5'd1) begin
      ch_wide = 5'd0;
    end else if (channel_order && ch_wide == 5'd2) begin
      ch_wide = 5'd1;
    end
    ch = ch_wide[INDEX_W-1:0];

    slot_counter_next  = slot_counter;
    awaiting_sync_next = awaiting_sync;
    sync_total_next    = sync_total;
    res_valid          = 1'b0;
    res_sync           = 1'b0;
    if (past_end) begin
      slot_counter_next  = '0;
      awaiting_sync_next = 1'b0;
    end else if (is_gap) begin
      slot_counter_next  = '0;
      awaiting_sync_next = 1'b0;
      sync_total_next    = sync_total + 1'b1;
      res_valid          = 1'b1;
      res_sync           = 1'b1;
    end else if (!awaiting_sync) begin
      slot_counter_next  = slot_counter + 1'b1;
      res_valid          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      slot_counter   <= '0;
      awaiting_sync  <= 1'b1;
      sync_total     <= '0;
    end else if (accept) begin
      last_edge_time <= s_tdata;
      slot_counter   <= slot_counter_next;
      awaiting_sync  <= awaiting_sync_next;
      sync_total     <= sync_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      is_sync_q       <= res_sync;
      channel_index_q <= res_sync ? '0 : ch;
      channel_value_q <= res_sync ? '0 : value;
      frame_count_q   <= sync_total_next;
    end
  end

  assign m_tuser = is_sync_q;
  assign m_tdata = {6'd0, frame_count_q, channel_value_q, channel_index_q};

  a_sync_fields_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[17:0] == 18'd0)
    else $error("sync result carries a channel index or value");

  a_sync_resets_slot : assert property (@(posedge clk) disable iff (rst)
    accept && res_sync |=> slot_counter == '0 && !awaiting_sync)
    else $error("frame sync did not restart the slot counter");

  a_slot_bound : assert property (@(posedge clk) disable iff (rst)
    slot_counter <= SLOT_W'(SLOT_COUNT))
    else $error("slot counter ran past the last slot");

  a_value_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      $signed(m_tdata[17:3]) >= -15'sd10000 && $signed(m_tdata[17:3]) <= 15'sd10000)
    else $error("channel value out of range");

  a_count_tracks : assert property (@(posedge clk) disable iff (rst)
    accept && res_valid |=> m_tvalid && m_tdata[25:18] == sync_total)
    else $error("reported frame count differs from the sync total");

endmodule
